>>> hw/rtl/pcs_pkg.sv
`default_nettype none
package pcs_pkg;
   localparam int CoordWidth = 24;
   localparam int DiffWidth  = CoordWidth + 3;
   localparam int NumWidth   = 2 * DiffWidth + 2;
   localparam int SqWidth    = 2 * DiffWidth + 1;
   localparam int RootWidth  = (SqWidth + 1) / 2;
   localparam int DenWidth   = SqWidth + RootWidth;
   localparam int DividendWidth = NumWidth + 24;
   localparam int CurvWidth  = 32;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DiffWidth-1:0] diff_type;

   // One curvature job handed from the front part to the back part.
   typedef struct packed {
      diff_type dx;
      diff_type dy;
      diff_type ddx;
      diff_type ddy;
      logic     final_result;
      logic     too_short;
   } job_type;
endpackage
`default_nettype wire

>>> hw/rtl/pcs_front.sv
`default_nettype none
module pcs_front
   import pcs_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire coord_type req_point_x,
   input  wire coord_type req_point_y,
   input  wire logic      req_end_of_line,
   output logic           job_valid,
   input  wire logic      job_stall,
   output job_type        job
);
   localparam logic [1:0] SlotCenter = 2'd0;
   localparam logic [1:0] SlotPrev   = 2'd1;
   localparam logic [1:0] SlotLast   = 2'd2;

   coord_type   wx_ff [5];
   coord_type   wy_ff [5];
   coord_type   wx_in [5];
   coord_type   wy_in [5];
   logic [2:0]  seen_ff, seen_in, span_cnt_ff, span_cnt_in;
   logic        span_end_ff, span_end_in;
   logic        busy_ff, busy_in;
   logic [1:0]  slot_ff, slot_in;
   logic        accept;
   logic [2:0]  r;
   diff_type    dx, dy, ax, ay, bx, by;
   logic [2:0]  ra, rb;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy_ff;

   function automatic logic first_at(input logic [2:0] idx, input logic [2:0] cnt);
      first_at = (cnt <= 3'd4) && (idx == 3'd4 - cnt);
   endfunction

   function automatic logic last_at(input logic [2:0] idx, input logic e);
      last_at = e && (idx == 3'd4);
   endfunction

   function automatic diff_type d1x(input logic [2:0] idx, input logic [2:0] cnt,
                                    input logic e, input coord_type p [5]);
      logic [2:0] a, b;
      a = idx + 3'd1; b = idx - 3'd1;
      if (first_at(idx, cnt)) b = idx;
      else if (last_at(idx, e)) a = idx;
      d1x = DiffWidth'(p[a]) - DiffWidth'(p[b]);
   endfunction

   always_comb begin
      unique case (slot_ff)
         SlotCenter: r = 3'd2;
         SlotPrev:   r = 3'd3;
         default:    r = 3'd4;
      endcase
      ra = r + 3'd1; rb = r - 3'd1;
      if (first_at(r, span_cnt_ff)) rb = r;
      else if (last_at(r, span_end_ff)) ra = r;
      dx = d1x(r, span_cnt_ff, span_end_ff, wx_ff);
      dy = d1x(r, span_cnt_ff, span_end_ff, wy_ff);
      ax = d1x(ra, span_cnt_ff, span_end_ff, wx_ff);
      ay = d1x(ra, span_cnt_ff, span_end_ff, wy_ff);
      bx = d1x(rb, span_cnt_ff, span_end_ff, wx_ff);
      by = d1x(rb, span_cnt_ff, span_end_ff, wy_ff);
      job.dx  = dx;
      job.dy  = dy;
      job.ddx = ax - bx;
      job.ddy = ay - by;
      job.final_result = (slot_ff == SlotLast);
      job.too_short    = span_end_ff && (span_cnt_ff == 3'd0);
      if (job.too_short) begin
         job.dx = '0; job.dy = '0; job.ddx = '0; job.ddy = '0;
      end
   end

   assign job_valid = busy_ff;

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         wx_in[k] = wx_ff[k];
         wy_in[k] = wy_ff[k];
      end
      seen_in = seen_ff; span_cnt_in = span_cnt_ff; span_end_in = span_end_ff;
      busy_in = busy_ff; slot_in = slot_ff;
      if (accept) begin
         for (int k = 0; k < 4; k++) begin
            wx_in[k] = wx_ff[k+1];
            wy_in[k] = wy_ff[k+1];
         end
         wx_in[4] = req_point_x;
         wy_in[4] = req_point_y;
         span_cnt_in = seen_ff;
         span_end_in = req_end_of_line;
         if (req_end_of_line) seen_in = 3'd0;
         else if (seen_ff != 3'd7) seen_in = seen_ff + 3'd1;
         if (req_end_of_line && seen_ff == 3'd0) begin
            busy_in = 1'b1; slot_in = SlotLast;
         end else if (seen_ff >= 3'd2) begin
            busy_in = 1'b1; slot_in = SlotCenter;
         end else if (req_end_of_line) begin
            busy_in = 1'b1; slot_in = SlotPrev;
         end
      end else if (busy_ff && !job_stall) begin
         if (slot_ff == SlotLast || !span_end_ff) busy_in = 1'b0;
         else slot_in = slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) begin
            wx_ff[k] <= '0;
            wy_ff[k] <= '0;
         end
         seen_ff     <= '0;
         busy_ff     <= 1'b0;
         span_cnt_ff <= '0;
         span_end_ff <= 1'b0;
         slot_ff     <= SlotCenter;
      end else begin
         for (int k = 0; k < 5; k++) begin
            wx_ff[k] <= wx_in[k];
            wy_ff[k] <= wy_in[k];
         end
         seen_ff     <= seen_in;
         busy_ff     <= busy_in;
         span_cnt_ff <= span_cnt_in;
         span_end_ff <= span_end_in;
         slot_ff     <= slot_in;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/pcs_queue.sv
`default_nettype none
module pcs_queue
   import pcs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire job_type in_job,
   output logic         out_valid,
   input  wire logic    out_stall,
   output job_type      out_job
);
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_job;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/pcs_back.sv
`default_nettype none
module pcs_back
   import pcs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   output logic         job_stall,
   input  wire job_type job,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic signed [CurvWidth-1:0] rsp_curvature,
   output logic         rsp_final_result,
   output logic         rsp_too_short
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StMul  = 3'd1;
   localparam logic [2:0] StSum  = 3'd2;
   localparam logic [2:0] StRoot = 3'd3;
   localparam logic [2:0] StDen  = 3'd4;
   localparam logic [2:0] StDiv  = 3'd5;
   localparam logic [2:0] StOut  = 3'd6;
   localparam int CntWidth = $clog2(DividendWidth);

   logic [2:0] st_ff, st_in;
   job_type    job_ff;
   logic signed [2*DiffWidth-1:0] p0_ff, p1_ff;
   logic [2*DiffWidth-1:0]   p2_ff, p3_ff;
   logic [NumWidth-1:0]      nmag_ff;
   logic                     neg_ff;
   logic [SqWidth-1:0]       s_ff;
   logic [RootWidth-1:0]     root_ff;
   logic [DenWidth-1:0]      den_ff;
   logic [DividendWidth-1:0] q_ff;
   logic [DenWidth:0]        rem_ff;
   logic [CntWidth-1:0]      cnt_ff;
   logic signed [CurvWidth-1:0] curv_ff;
   logic signed [NumWidth-1:0]  num;
   logic [RootWidth-1:0]     trial;
   logic [2*RootWidth-1:0]   trial_sq;
   logic [DenWidth:0]        rem_sh;
   logic                     q_bit;
   logic [DividendWidth-1:0] q_next;
   logic [DiffWidth-1:0]     mdx, mdy;

   assign job_stall = (st_ff != StIdle);
   assign rsp_valid = (st_ff == StOut);
   assign rsp_curvature    = curv_ff;
   assign rsp_final_result = job_ff.final_result;
   assign rsp_too_short    = job_ff.too_short;

   assign num = NumWidth'(p0_ff) - NumWidth'(p1_ff);
   assign mdx = job_ff.dx[DiffWidth-1] ? DiffWidth'(-job_ff.dx) : job_ff.dx;
   assign mdy = job_ff.dy[DiffWidth-1] ? DiffWidth'(-job_ff.dy) : job_ff.dy;
   assign trial    = root_ff | (RootWidth'(1) << cnt_ff);
   assign trial_sq = trial * trial;
   assign rem_sh   = {rem_ff[DenWidth-1:0], q_ff[DividendWidth-1]};
   assign q_bit    = (rem_sh >= {1'b0, den_ff});
   assign q_next   = {q_ff[DividendWidth-2:0], q_bit};

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         StIdle: if (job_valid) st_in = StMul;
         StMul:  st_in = StSum;
         StSum:  st_in = StRoot;
         StRoot: if (cnt_ff == '0) st_in = StDen;
         StDen:  st_in = (root_ff == '0) ? StOut : StDiv;
         StDiv:  if (cnt_ff == '0) st_in = StOut;
         StOut:  if (!rsp_stall) st_in = StIdle;
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         StIdle: job_ff <= job;
         StMul: begin
            p0_ff <= job_ff.dx * job_ff.ddy;
            p1_ff <= job_ff.dy * job_ff.ddx;
            p2_ff <= mdx * mdx;
            p3_ff <= mdy * mdy;
         end
         StSum: begin
            neg_ff  <= num[NumWidth-1];
            nmag_ff <= num[NumWidth-1] ? NumWidth'(-num) : num;
            s_ff    <= SqWidth'(p2_ff) + SqWidth'(p3_ff);
            root_ff <= '0;
            den_ff  <= '0;
            cnt_ff  <= CntWidth'(RootWidth - 1);
         end
         StRoot: begin
            // each root bit is final once set, so S * root builds up alongside
            if ({1'b0, trial_sq} <= (2*RootWidth+1)'(s_ff)) begin
               root_ff <= trial;
               den_ff  <= den_ff + (DenWidth'(s_ff) << cnt_ff);
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
         StDen: begin
            q_ff   <= {nmag_ff, 24'd0};
            rem_ff <= '0;
            cnt_ff <= CntWidth'(DividendWidth - 1);
            curv_ff <= '0;
         end
         StDiv: begin
            rem_ff <= q_bit ? rem_sh - {1'b0, den_ff} : rem_sh;
            q_ff   <= q_next;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (neg_ff)
                  curv_ff <= (q_next >= DividendWidth'(33'h80000000)) ? 32'sh80000000
                             : CurvWidth'(-q_next);
               else
                  curv_ff <= (q_next > DividendWidth'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                             : CurvWidth'(q_next);
            end
         end
         default: begin
         end
      endcase
      if (reset) st_ff <= StIdle;
      else       st_ff <= st_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/polyline_curvature_stream_core.sv
`default_nettype none
// Streaming polyline curvature. One point per req beat; a beat gives zero to three rsp
// beats (point j-2 when point j arrives, the rest flushed on end_of_line). The front part
// takes a point and issues one job per result; the back part computes each result with
// a bit-serial square root of COORD + 4 steps, then a restoring divide of 2*COORD + 32
// steps, and holds it while rsp stalls; a null tangent skips the divide. The back part
// takes a new job only once its last result is out, and the front stalls req while its
// jobs wait for room. A two-entry queue decouples the parts.
// Curvature is signed Q8.24, saturated, zero for a null tangent.
module polyline_curvature_stream_core
   import pcs_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire coord_type req_point_x,
   input  wire coord_type req_point_y,
   input  wire logic      req_end_of_line,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output logic signed [CurvWidth-1:0] rsp_curvature,
   output logic           rsp_final_result,
   output logic           rsp_too_short
);
   logic    f_valid, f_stall, b_valid, b_stall;
   job_type f_job, b_job;

   pcs_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_point_x, .req_point_y,
      .req_end_of_line, .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
   );

   pcs_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_job(f_job),
      .out_valid(b_valid), .out_stall(b_stall), .out_job(b_job)
   );

   pcs_back u_back (
      .clock, .reset, .job_valid(b_valid), .job_stall(b_stall), .job(b_job),
      .rsp_valid, .rsp_stall, .rsp_curvature, .rsp_final_result, .rsp_too_short
   );
endmodule
`default_nettype wire

>>> bench/tb_polyline_curvature_stream_core.sv
`default_nettype none
module tb_polyline_curvature_stream_core;
   timeunit 1ns;
   timeprecision 1ps;
   import pcs_pkg::*;

   localparam int IdleLimit = 4000;
   localparam int HoldCycles = 500;
   localparam int DrainCycles = 400;

   typedef struct {
      logic signed [CurvWidth-1:0] curvature;
      logic                        final_result;
      logic                        too_short;
   } curv_result_type;

   class curvature_board;
      longint       win_x[4];
      longint       win_y[4];
      int unsigned  pts_seen;
      longint       sp_x[5];
      longint       sp_y[5];
      int unsigned  sp_count;
      bit           sp_end;
      curv_result_type pending_q[$];
      int           errors;

      function new();
         foreach (win_x[k]) begin
            win_x[k] = 0;
            win_y[k] = 0;
         end
         pts_seen = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function bit at_first(int r);
         return sp_count <= 4 && r == 4 - int'(sp_count);
      endfunction

      function void diff_pair(int r, output int a, output int b);
         if (at_first(r)) begin
            a = r + 1;
            b = r;
         end else if (sp_end && r == 4) begin
            a = r;
            b = r - 1;
         end else begin
            a = r + 1;
            b = r - 1;
         end
      endfunction

      function void slope(int r, output longint dx, output longint dy);
         int a, b;
         diff_pair(r, a, b);
         dx = sp_x[a] - sp_x[b];
         dy = sp_y[a] - sp_y[b];
      endfunction

      function logic [31:0] curvature_of(int r);
         longint dx, dy, ax, ay, bx, by, ddx, ddy, num, sq;
         int a, b;
         bit neg;
         logic [127:0] mag, numer, root, t, den, quo;
         slope(r, dx, dy);
         diff_pair(r, a, b);
         slope(a, ax, ay);
         slope(b, bx, by);
         ddx = ax - bx;
         ddy = ay - by;
         num = dx * ddy - dy * ddx;
         neg = num < 0;
         mag = neg ? 128'(-num) : 128'(num);
         numer = mag << 24;
         sq = dx * dx + dy * dy;
         root = 0;
         for (int k = 35; k >= 0; k--) begin
            t = root | (128'd1 << k);
            if (t * t <= 128'(sq)) root = t;
         end
         if (root == 0) return 32'd0;
         den = 128'(sq) * root;
         quo = numer / den;
         if (neg) begin
            if (quo >= 128'h8000_0000) return 32'h8000_0000;
            return 32'(-quo[31:0]);
         end
         if (quo > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
         return quo[31:0];
      endfunction

      function void push_result(logic [31:0] c, logic f, logic s);
         curv_result_type e;
         e.curvature = c;
         e.final_result = f;
         e.too_short = s;
         pending_q = {pending_q, e};
      endfunction

      // Accepted point: predict the beats it releases.
      function void note_point(coord_type x, coord_type y, logic eol);
         int unsigned c;
         c = pts_seen;
         for (int k = 0; k < 4; k++) begin
            sp_x[k] = win_x[k];
            sp_y[k] = win_y[k];
         end
         sp_x[4] = longint'(x);
         sp_y[4] = longint'(y);
         sp_count = c;
         sp_end = eol;
         if (eol && c == 0) begin
            push_result(32'd0, 1'b1, 1'b1);
         end else begin
            if (c >= 2) push_result(curvature_of(2), 1'b0, 1'b0);
            if (eol) begin
               push_result(curvature_of(3), 1'b0, 1'b0);
               push_result(curvature_of(4), 1'b1, 1'b0);
            end
         end
         for (int k = 0; k < 4; k++) begin
            win_x[k] = sp_x[k + 1];
            win_y[k] = sp_y[k + 1];
         end
         if (eol) pts_seen = 0;
         else if (c < 7) pts_seen = c + 1;
      endfunction

      task check_result(logic [31:0] c, logic f, logic s);
         curv_result_type e;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected beat curv=%h final=%b short=%b", c, f, s));
            return;
         end
         e = pending_q.pop_front();
         if (c !== e.curvature)
            report($sformatf("curvature %h, want %h", c, e.curvature));
         if (f !== e.final_result)
            report($sformatf("final_result %b, want %b", f, e.final_result));
         if (s !== e.too_short)
            report($sformatf("too_short %b, want %b", s, e.too_short));
      endtask
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   logic      req_end_of_line = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic signed [CurvWidth-1:0] rsp_curvature;
   logic      rsp_final_result;
   logic      rsp_too_short;

   curvature_board board = new();
   int  idle_count = 0;
   bit  hold_req = 0;
   bit  rsp_calm = 0;
   int  hold_left = 0;
   int  wait_left = 0;
   coord_type last_x = '0;
   coord_type last_y = '0;

   polyline_curvature_stream_core dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: check accepted beats, draw stalls.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_result(rsp_curvature, rsp_final_result, rsp_too_short);
            wait_left = rsp_calm ? 0 : $urandom_range(0, 3);
         end
         if (hold_req && hold_left == 0) begin
            hold_left = HoldCycles;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 199) == 0) rsp_calm = !rsp_calm;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= IdleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task send_point(coord_type x, coord_type y, logic eol, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_end_of_line <= eol;
      do @(posedge clock); while (req_stall);
      board.note_point(x, y, eol);
      last_x = x;
      last_y = y;
   endtask

   function automatic coord_type pick_coord(coord_type prev);
      int m;
      m = $urandom_range(0, 9);
      if (m < 5) return prev + coord_type'($urandom_range(0, 2000)) - coord_type'(1000);
      if (m < 8) return coord_type'($urandom);
      if (m == 8) return coord_type'({1'b1, {(CoordWidth-1){1'b0}}});
      return coord_type'({1'b0, {(CoordWidth-1){1'b1}}});
   endfunction

   task send_line(int len, bit burst);
      for (int k = 0; k < len; k++)
         send_point(pick_coord(last_x), pick_coord(last_y), k == len - 1,
                    burst ? 0 : $urandom_range(0, 3));
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   localparam coord_type CMax = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam coord_type CMin = {1'b1, {(CoordWidth-1){1'b0}}};

   initial begin
      int len;
      int sent;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single point, two and three point lines
      send_point(CMax, CMin, 1'b1, 0);
      send_point(CMin, CMax, 1'b0, 1);
      send_point(CMax, CMin, 1'b1, 0);
      send_point('0, '0, 1'b0, 0);
      send_point(CMax, '0, 1'b0, 2);
      send_point(CMax, CMax, 1'b1, 0);
      // repeated points: null tangent
      repeat (3) send_point(24'sd77, -24'sd5, 1'b0, 0);
      send_point(24'sd77, -24'sd5, 1'b1, 0);
      // straight line, then tight turns with alternating extremes
      for (int k = 0; k < 5; k++)
         send_point(coord_type'(k * 10), coord_type'(k * 10), k == 4, 0);
      for (int k = 0; k < 9; k++)
         send_point(k[0] ? CMax : CMin, k[1] ? CMin : CMax, k == 8, 0);
      wait_drained();

      // long receiver hold-off while points keep coming
      hold_req = 1;
      send_line(12, 1);
      wait_drained();

      sent = 0;
      while (sent < 190) begin
         len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 9);
         if ($urandom_range(0, 15) == 0) len = $urandom_range(10, 16);
         send_line(len, $urandom_range(0, 4) == 0);
         sent += len;
      end
      // close a line left open, if any
      send_point(pick_coord(last_x), pick_coord(last_y), 1'b1, 0);
      wait_drained();

      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
